// ----- rtl/core/tlpd_pkg.sv -----
package tlpd_pkg;

  localparam logic [31:0] TAG_JSON = 32'h4A534F4E;
  localparam logic [31:0] TAG_VIDE = 32'h56494445;
  localparam logic [31:0] MAX_LENGTH_RESET = 32'd10485760;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam logic [0:0] REG_MAX_LENGTH = 1'b0;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_DISCONNECT = 1'b1;

  localparam logic [1:0] PH_HUNT = 2'd0;
  localparam logic [1:0] PH_LEN = 2'd1;
  localparam logic [1:0] PH_PAY = 2'd2;

  localparam logic KIND_JSON = 1'b0;
  localparam logic KIND_VIDE = 1'b1;

  typedef struct packed {
    logic       packet_kind;
    logic [7:0] payload_byte;
    logic       last_byte;
    logic       empty_packet;
    logic       length_error;
  } result_t;

endpackage

// ----- rtl/core/tlpd_cfg.sv -----
module tlpd_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [tlpd_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [31:0]                       cfg_pwdata,
  output logic [31:0]                       cfg_prdata,
  output logic                              cfg_pready,
  output logic [31:0]                       max_length
);

  logic [31:0] max_length_r;
  logic [31:0] max_length_nxt;
  logic        reg_sel;

  assign reg_sel = (cfg_paddr[tlpd_pkg::CFG_ADDR_W-1] == tlpd_pkg::REG_MAX_LENGTH);

  always_comb begin
    max_length_nxt = max_length_r;
    if (cfg_psel && cfg_penable && cfg_pwrite && reg_sel) begin
      max_length_nxt = cfg_pwdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_length_r <= tlpd_pkg::MAX_LENGTH_RESET;
    end else begin
      max_length_r <= max_length_nxt;
    end
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = reg_sel ? max_length_r : 32'd0;
  assign max_length = max_length_r;

endmodule

// ----- rtl/core/tlpd_core.sv -----
module tlpd_core (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [31:0]             max_length,
  input  logic                    in_fire,
  input  logic                    in_cmd,
  input  logic [7:0]              in_data_byte,
  output logic                    res_vld,
  output tlpd_pkg::result_t       res
);

  logic [23:0] win_r, win_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic        kind_r, kind_nxt;
  logic [1:0]  idx_r, idx_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [31:0] left_r, left_nxt;
  logic [31:0] word;
  logic        last;

  assign word = {win_r, in_data_byte};
  assign last = (left_r <= 32'd1);

  always_comb begin
    win_nxt = win_r;
    phase_nxt = phase_r;
    kind_nxt = kind_r;
    idx_nxt = idx_r;
    acc_nxt = acc_r;
    left_nxt = left_r;
    res_vld = 1'b0;
    res = '0;
    res.packet_kind = kind_r;
    if (in_fire) begin
      if (in_cmd == tlpd_pkg::CMD_DISCONNECT) begin
        win_nxt = '0;
        phase_nxt = tlpd_pkg::PH_HUNT;
        kind_nxt = 1'b0;
        idx_nxt = '0;
        acc_nxt = '0;
        left_nxt = '0;
      end else begin
        case (phase_r)
          tlpd_pkg::PH_LEN: begin
            acc_nxt = {acc_r[23:0], in_data_byte};
            if (idx_r != 2'd3) begin
              idx_nxt = idx_r + 2'd1;
            end else begin
              idx_nxt = '0;
              phase_nxt = tlpd_pkg::PH_HUNT;
              if (acc_nxt > max_length) begin
                res_vld = 1'b1;
                res.length_error = 1'b1;
              end else if (acc_nxt == 32'd0) begin
                res_vld = 1'b1;
                res.last_byte = 1'b1;
                res.empty_packet = 1'b1;
              end else begin
                left_nxt = acc_nxt;
                phase_nxt = tlpd_pkg::PH_PAY;
              end
            end
          end
          tlpd_pkg::PH_PAY: begin
            res_vld = 1'b1;
            res.payload_byte = in_data_byte;
            res.last_byte = last;
            left_nxt = last ? 32'd0 : left_r - 32'd1;
            if (last) begin
              phase_nxt = tlpd_pkg::PH_HUNT;
            end
          end
          default: begin
            if (word == tlpd_pkg::TAG_JSON || word == tlpd_pkg::TAG_VIDE) begin
              kind_nxt = (word == tlpd_pkg::TAG_VIDE) ? tlpd_pkg::KIND_VIDE
                                                      : tlpd_pkg::KIND_JSON;
              win_nxt = '0;
              idx_nxt = '0;
              acc_nxt = '0;
              left_nxt = '0;
              phase_nxt = tlpd_pkg::PH_LEN;
            end else begin
              win_nxt = word[23:0];
              phase_nxt = tlpd_pkg::PH_HUNT;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
      phase_r <= tlpd_pkg::PH_HUNT;
      kind_r <= 1'b0;
      idx_r <= '0;
      acc_r <= '0;
      left_r <= '0;
    end else begin
      win_r <= win_nxt;
      phase_r <= phase_nxt;
      kind_r <= kind_nxt;
      idx_r <= idx_nxt;
      acc_r <= acc_nxt;
      left_r <= left_nxt;
    end
  end

endmodule

// ----- rtl/core/tlpd_outbuf.sv -----
module tlpd_outbuf (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    res_vld,
  input  tlpd_pkg::result_t       res,
  input  logic                    out_stall,
  output logic                    out_valid,
  output tlpd_pkg::result_t       out_res,
  output logic                    full
);

  logic              out_vld_r, out_vld_nxt;
  logic              skid_vld_r, skid_vld_nxt;
  tlpd_pkg::result_t out_r, out_nxt;
  tlpd_pkg::result_t skid_r, skid_nxt;
  logic              out_fire;

  assign out_fire = out_vld_r && !out_stall;

  always_comb begin
    out_vld_nxt = out_vld_r;
    skid_vld_nxt = skid_vld_r;
    out_nxt = out_r;
    skid_nxt = skid_r;
    if (skid_vld_r) begin
      if (out_fire) begin
        out_nxt = skid_r;
        skid_vld_nxt = 1'b0;
      end
    end else if (out_vld_r && !out_fire) begin
      if (res_vld) begin
        skid_nxt = res;
        skid_vld_nxt = 1'b1;
      end
    end else begin
      out_vld_nxt = res_vld;
      out_nxt = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_res = out_r;
  assign full = skid_vld_r;

endmodule

// ----- rtl/core/tag_length_packet_deframer_unit.sv -----
// Each result is registered in the output buffer before it appears at the outputs.
// One input byte is accepted per cycle while in_stall is low.
// A two-entry output buffer lets input continue while one result waits.
// Reset (rst_n low, synchronous) returns the parser to tag hunting, empties
// the output buffer and sets max_length to 10485760.
module tag_length_packet_deframer_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [tlpd_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]                     cfg_pwdata,
  output logic [31:0]                     cfg_prdata,
  output logic                            cfg_pready,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_cmd,
  input  logic [7:0]                      in_data_byte,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_packet_kind,
  output logic [7:0]                      out_payload_byte,
  output logic                            out_last_byte,
  output logic                            out_empty_packet,
  output logic                            out_length_error
);

  logic              in_fire;
  logic [31:0]       max_length;
  logic              res_vld;
  tlpd_pkg::result_t res;
  tlpd_pkg::result_t out_res;
  logic              full;

  assign in_stall = full;
  assign in_fire = in_valid && !in_stall;

  tlpd_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .max_length  (max_length)
  );

  tlpd_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .max_length   (max_length),
    .in_fire      (in_fire),
    .in_cmd       (in_cmd),
    .in_data_byte (in_data_byte),
    .res_vld      (res_vld),
    .res          (res)
  );

  tlpd_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_vld   (res_vld),
    .res       (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_res   (out_res),
    .full      (full)
  );

  assign out_packet_kind = out_res.packet_kind;
  assign out_payload_byte = out_res.payload_byte;
  assign out_last_byte = out_res.last_byte;
  assign out_empty_packet = out_res.empty_packet;
  assign out_length_error = out_res.length_error;

`ifndef SYNTHESIS
  a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid) else $error("input stalled with no result pending");

  a_disconnect_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_cmd && !out_valid) |=> !out_valid)
    else $error("disconnect produced a result");

  a_error_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_length_error) |->
      (!out_last_byte && !out_empty_packet && out_payload_byte == 8'd0))
    else $error("malformed length error result");

  a_empty_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_empty_packet) |-> (out_last_byte && out_payload_byte == 8'd0))
    else $error("malformed empty packet result");
`endif

endmodule
